// ===== sv/ovn_pkg.sv =====
// ----------------------------------------------------------------------------
// Octave value noise package
// Shared constants, codes and transfer types of the octave value noise unit.
// ----------------------------------------------------------------------------
package ovn_pkg;

  localparam int GRID_BITS = 8;
  localparam int GRID_SIDE = 1 << GRID_BITS;
  localparam int SEED_W    = 16;
  localparam int OCT_W     = 4;
  localparam int OCT_IDX_W = 3;
  localparam int OCT_MAX   = 8;
  localparam int ACC_W     = SEED_W + OCT_MAX;
  localparam int RAM_AW    = 2 * GRID_BITS;
  localparam int RAM_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [OCT_W-1:0]    OCT_RESET        = 4'd6;
  localparam logic [APB_AW-3:0]   REG_OCTAVE_COUNT = 1'b0;
  localparam logic                FUNC_LOAD        = 1'b0;
  localparam logic                FUNC_QUERY       = 1'b1;

  typedef enum logic {
    OP_LOAD,
    OP_QUERY
  } op_e;

  typedef enum logic {
    BK_IDLE,
    BK_QUERY
  } back_state_e;

  typedef struct packed {
    logic                 func;
    logic [GRID_BITS-1:0] pos_x;
    logic [GRID_BITS-1:0] pos_y;
    logic [SEED_W-1:0]    seed_value;
  } in_item_t;

  typedef struct packed {
    logic [SEED_W-1:0]    noise_value;
    logic [GRID_BITS-1:0] out_x;
    logic [GRID_BITS-1:0] out_y;
  } out_item_t;

  typedef struct packed {
    op_e                  op;
    logic [GRID_BITS-1:0] x;
    logic [GRID_BITS-1:0] y;
    logic [SEED_W-1:0]    seed;
    logic [OCT_W-1:0]     oct;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_push_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

endpackage

// ===== sv/ovn_stream_if.sv =====
// ----------------------------------------------------------------------------
// Octave value noise stream interface
// Valid/ready channel with a typed payload; a transfer happens when both are high.
// ----------------------------------------------------------------------------
interface ovn_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== sv/octave_value_noise_2d_unit.sv =====
// ----------------------------------------------------------------------------
// Octave value noise unit
// A load transfer writes one seed once it reaches the engine.
// A query with K octaves issues 4*K seed reads on the one RAM port, one per cycle;
// its result passes the blend pipeline, the octave sum and the normalizer in turn.
// A new query starts only once the blend pipeline has drained the previous one.
// Reset sets the octave count to 6 and empties all stages; seeds are not cleared.
// ----------------------------------------------------------------------------
module octave_value_noise_2d_unit
  import ovn_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  ovn_stream_if.sink        in_ch,
  ovn_stream_if.source      out_ch
);

  q_push_t push;
  q_head_t head;
  logic    q_ready;
  logic    pop;

  ovn_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .q_ready_i (q_ready),
    .push_o    (push)
  );

  ovn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .head_o  (head),
    .pop_i   (pop)
  );

  ovn_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== sv/ovn_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, with registered read data.
// ----------------------------------------------------------------------------
module ovn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ovn_queue.sv =====
// ----------------------------------------------------------------------------
// Octave value noise job queue
// Short FIFO of classified jobs between the front end and the engine.
// ----------------------------------------------------------------------------
module ovn_queue
  import ovn_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_push_t push_i,
  output logic    ready_o,
  output q_head_t head_o,
  input  logic    pop_i
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            pop;

  assign ready_o      = (count_q != CntW'(DEPTH));
  assign push         = push_i.valid && ready_o;
  assign pop          = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.job   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== sv/ovn_front.sv =====
// ----------------------------------------------------------------------------
// Octave value noise front end
// Holds the octave count register and turns input transfers into queued jobs.
// ----------------------------------------------------------------------------
module ovn_front
  import ovn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  ovn_stream_if.sink        in_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              q_ready_i,
  output q_push_t           push_o
);

  logic [OCT_W-1:0] oct_q;
  logic [OCT_W-1:0] oct_eff;
  logic             reg_hit;

  assign reg_hit = (paddr[APB_AW-1:2] == REG_OCTAVE_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DW'(oct_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q <= OCT_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      oct_q <= pwdata[OCT_W-1:0];
    end
  end

  // A count of zero acts as one octave and counts above the maximum saturate.
  always_comb begin
    if (oct_q == '0) begin
      oct_eff = OCT_W'(1);
    end else if (oct_q > OCT_W'(OCT_MAX)) begin
      oct_eff = OCT_W'(OCT_MAX);
    end else begin
      oct_eff = oct_q;
    end
  end

  assign in_ch.ready     = q_ready_i;
  assign push_o.valid    = in_ch.valid && q_ready_i;
  assign push_o.job.op   = (in_ch.payload.func == FUNC_QUERY) ? OP_QUERY : OP_LOAD;
  assign push_o.job.x    = in_ch.payload.pos_x;
  assign push_o.job.y    = in_ch.payload.pos_y;
  assign push_o.job.seed = in_ch.payload.seed_value;
  assign push_o.job.oct  = oct_eff;

endmodule

// ===== sv/ovn_back.sv =====
// ----------------------------------------------------------------------------
// Octave value noise engine
// Reads corner seeds, blends and sums octaves, and normalizes the sum.
// ----------------------------------------------------------------------------
module ovn_back
  import ovn_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  q_head_t      head_i,
  output logic         pop_o,
  ovn_stream_if.source out_ch
);

  localparam int PitchW  = GRID_BITS + 1;
  localparam int WeightW = 2 * GRID_BITS + 1;
  localparam int ProdW   = SEED_W + 2 * GRID_BITS;
  localparam int ShiftW  = $clog2(2 * GRID_BITS + 1);
  localparam int DivW    = OCT_MAX;
  localparam int DivXW   = DivW + 1;
  localparam int RecipW  = ACC_W + 2;
  localparam int NProdW  = ACC_W + RecipW;
  localparam int NShW    = $clog2(ACC_W + OCT_MAX + 1);

  typedef struct packed {
    logic                 first_c;
    logic                 last_c;
    logic                 last_o;
    logic [OCT_IDX_W-1:0] oct;
  } tag_t;

  back_state_e          state_q, state_d;
  logic [OCT_IDX_W-1:0] oct_q;
  logic [1:0]           corner_q;
  logic [GRID_BITS-1:0] cur_x_q, cur_y_q;
  logic [OCT_W-1:0]     cur_k_q;

  logic [PitchW-1:0]    pitch;
  logic [GRID_BITS-1:0] mask, x1, y1, x2, y2, xc, yc, dx, dy;
  logic [PitchW-1:0]    wx, wy;
  logic [WeightW-1:0]   weight;
  logic                 last_c, last_o, issue, load_go, q_start, pipe_busy;

  logic                 ram_we;
  logic [RAM_AW-1:0]    ram_addr;
  logic [SEED_W-1:0]    ram_rdata;

  logic                 s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  tag_t                 s1_tag_q, s2_tag_q, s3_tag_q, s4_tag_q;
  logic [WeightW-1:0]   s1_w_q;
  logic [ProdW-1:0]     s2_prod_q;
  logic [ProdW-1:0]     v_sum, v_q, v_rnd;
  logic [ShiftW-1:0]    sh;
  logic [SEED_W-1:0]    sample, sample_q;
  logic [OCT_IDX_W-1:0] sa;
  logic [ACC_W-1:0]     term, acc_sum, acc_q;
  logic                 fin_q;

  logic                 div_busy_q, div_done_q, div_start;
  logic [DivW-1:0]      t_val;
  logic [DivXW-1:0]     t_full;
  logic [RecipW-1:0]    recip;
  logic [NProdW-1:0]    nprod_q;
  logic [NShW-1:0]      nsh_q;
  logic [SEED_W-1:0]    quo_q;
  logic [GRID_BITS-1:0] div_x_q, div_y_q;
  logic [ACC_W-1:0]     num;
  logic                 out_vld_q, out_load;
  out_item_t            out_q;

  // Corner addresses and bilinear weights of the current octave.
  always_comb begin
    pitch  = PitchW'(GRID_SIDE) >> oct_q;
    mask   = GRID_BITS'(pitch - PitchW'(1));
    x1     = cur_x_q & ~mask;
    y1     = cur_y_q & ~mask;
    dx     = cur_x_q & mask;
    dy     = cur_y_q & mask;
    x2     = x1 + pitch[GRID_BITS-1:0];
    y2     = y1 + pitch[GRID_BITS-1:0];
    xc     = corner_q[0] ? x2 : x1;
    yc     = corner_q[1] ? y2 : y1;
    wx     = corner_q[0] ? {1'b0, dx} : pitch - {1'b0, dx};
    wy     = corner_q[1] ? {1'b0, dy} : pitch - {1'b0, dy};
    weight = WeightW'(wx) * WeightW'(wy);
    last_c = (corner_q == 2'd3);
    last_o = ((OCT_W'(oct_q) + OCT_W'(1)) == cur_k_q);
  end

  assign pipe_busy = s1_vld_q || s2_vld_q || s3_vld_q || s4_vld_q || fin_q;
  assign issue     = (state_q == BK_QUERY);

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    load_go = 1'b0;
    q_start = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (head_i.valid) begin
          if (head_i.job.op == OP_LOAD) begin
            load_go = 1'b1;
            pop_o   = 1'b1;
          end else if (!pipe_busy) begin
            q_start = 1'b1;
            pop_o   = 1'b1;
            state_d = BK_QUERY;
          end
        end
      end
      BK_QUERY: begin
        if (last_c && last_o) begin
          state_d = BK_IDLE;
        end
      end
    endcase
  end

  assign ram_we   = load_go;
  assign ram_addr = load_go ? {head_i.job.y, head_i.job.x} : {yc, xc};

  ovn_ram #(
    .WIDTH (SEED_W),
    .DEPTH (RAM_DEPTH)
  ) u_seed_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (head_i.job.seed),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    v_sum   = (s2_tag_q.first_c ? '0 : v_q) + s2_prod_q;
    sh      = ShiftW'(2 * GRID_BITS) - ShiftW'({s3_tag_q.oct, 1'b0});
    v_rnd   = v_q + (ProdW'(1) << (sh - ShiftW'(1)));
    sample  = SEED_W'(v_rnd >> sh);
    sa      = OCT_IDX_W'(cur_k_q - OCT_W'(1) - OCT_W'(s4_tag_q.oct));
    term    = ACC_W'(sample_q) << sa;
    acc_sum = ((s4_tag_q.oct == '0) ? '0 : acc_q) + term;
  end

  always_comb begin
    t_full    = DivXW'(1) << cur_k_q;
    t_val     = DivW'(t_full - DivXW'(1));
    num       = acc_q + ACC_W'(t_val >> 1);
    div_start = fin_q && !div_busy_q && !div_done_q;
    out_load  = div_done_q && (!out_vld_q || out_ch.ready);
  end

  // The reciprocal is ceil(2^(24+K) / (2^K - 1)); the product shifted right by
  // 24+K gives the exact quotient for every sum below 2^24.
  always_comb begin
    case (cur_k_q)
      4'd1:    recip = RecipW'(33554432);
      4'd2:    recip = RecipW'(22369622);
      4'd3:    recip = RecipW'(19173962);
      4'd4:    recip = RecipW'(17895698);
      4'd5:    recip = RecipW'(17318417);
      4'd6:    recip = RecipW'(17043522);
      4'd7:    recip = RecipW'(16909321);
      default: recip = RecipW'(16843010);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      s3_vld_q   <= 1'b0;
      s4_vld_q   <= 1'b0;
      fin_q      <= 1'b0;
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q && s2_tag_q.last_c;
      s4_vld_q <= s3_vld_q;
      if (s4_vld_q && s4_tag_q.last_o) begin
        fin_q <= 1'b1;
      end else if (div_start) begin
        fin_q <= 1'b0;
      end
      if (div_start) begin
        div_busy_q <= 1'b1;
      end else if (div_busy_q) begin
        div_busy_q <= 1'b0;
        div_done_q <= 1'b1;
      end else if (out_load) begin
        div_done_q <= 1'b0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_start) begin
      cur_x_q  <= head_i.job.x;
      cur_y_q  <= head_i.job.y;
      cur_k_q  <= head_i.job.oct;
      oct_q    <= '0;
      corner_q <= '0;
    end else if (issue) begin
      corner_q <= corner_q + 2'd1;
      if (last_c) begin
        oct_q <= oct_q + OCT_IDX_W'(1);
      end
    end
    s1_tag_q  <= '{first_c: (corner_q == 2'd0), last_c: last_c, last_o: last_o, oct: oct_q};
    s1_w_q    <= weight;
    s2_tag_q  <= s1_tag_q;
    s2_prod_q <= ProdW'(ram_rdata) * ProdW'(s1_w_q);
    if (s2_vld_q) begin
      v_q <= v_sum;
    end
    s3_tag_q <= s2_tag_q;
    s4_tag_q <= s3_tag_q;
    sample_q <= sample;
    if (s4_vld_q) begin
      acc_q <= acc_sum;
    end
    if (div_start) begin
      nprod_q <= NProdW'(num) * NProdW'(recip);
      nsh_q   <= NShW'(ACC_W) + NShW'(cur_k_q);
      div_x_q <= cur_x_q;
      div_y_q <= cur_y_q;
    end
    if (div_busy_q) begin
      quo_q <= SEED_W'(nprod_q >> nsh_q);
    end
    if (out_load) begin
      out_q <= '{noise_value: quo_q, out_x: div_x_q, out_y: div_y_q};
    end
  end

  assign out_ch.valid   = out_vld_q;
  assign out_ch.payload = out_q;

`ifndef NO_ASSERTIONS
  a_quo_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> ((nprod_q >> nsh_q) <= NProdW'({SEED_W{1'b1}})))
    else $error("normalized noise exceeds the sample range");

  a_no_write_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_QUERY) |-> !ram_we)
    else $error("seed write while corner reads are issued");

  a_acc_not_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_vld_q |-> !fin_q)
    else $error("finished octave sum overwritten before normalization");

  a_fin_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_vld_q && s4_tag_q.last_o) |=> fin_q)
    else $error("last octave did not hand off its sum");
`endif

endmodule

// ===== bench/octave_value_noise_2d_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Octave value noise unit testbench
// Loads seeds and queries the noise at grid points over several octave counts.
// Each query is predicted from a local copy of the seed grid and the octave
// register, and every result transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module octave_value_noise_2d_unit_tb;
  import ovn_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int PHASE_ITEMS    = 80;
  localparam int NUM_PHASES     = 11;
  localparam logic [APB_AW-1:0] OCT_ADDR   = {REG_OCTAVE_COUNT, 2'b00};
  localparam logic [APB_AW-1:0] SPARE_ADDR = {~REG_OCTAVE_COUNT, 2'b00};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ovn_stream_if #(.payload_t(in_item_t))  in_ch ();
  ovn_stream_if #(.payload_t(out_item_t)) out_ch ();

  octave_value_noise_2d_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  logic [OCT_W-1:0] phase_octs [NUM_PHASES] =
    '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6};

  logic [SEED_W-1:0] seed_copy [RAM_DEPTH];
  bit                seed_written [RAM_DEPTH];
  logic [OCT_W-1:0]  octave_cfg;
  in_item_t          items_to_send [$];
  out_item_t         noise_due [$];
  int                queued_count;
  int                fill_seed = -1;
  int                mismatches;
  int                idle_cycles;
  int                in_gap;
  int                out_gap;
  bit                in_taken;
  bit                quiet;

  always #5 clk_i = ~clk_i;

  function automatic int octaves_used(input logic [OCT_W-1:0] reg_value);
    if (reg_value == 0) return 1;
    if (reg_value > OCT_MAX) return OCT_MAX;
    return int'(reg_value);
  endfunction

  function automatic logic [SEED_W-1:0] noise_at(input logic [GRID_BITS-1:0] px,
                                                  input logic [GRID_BITS-1:0] py);
    int          octs, o, pitch, x0, y0, x1, y1, dx, dy;
    logic [47:0] top, bot, blend, area, sum, total;
    octs = octaves_used(octave_cfg);
    sum = '0;
    for (o = 0; o < octs; o++) begin
      pitch = GRID_SIDE >> o;
      x0 = (int'(px) / pitch) * pitch;
      y0 = (int'(py) / pitch) * pitch;
      x1 = (x0 + pitch) % GRID_SIDE;
      y1 = (y0 + pitch) % GRID_SIDE;
      dx = int'(px) - x0;
      dy = int'(py) - y0;
      top = 48'(seed_copy[y0 * GRID_SIDE + x0]) * 48'(pitch - dx)
          + 48'(seed_copy[y0 * GRID_SIDE + x1]) * 48'(dx);
      bot = 48'(seed_copy[y1 * GRID_SIDE + x0]) * 48'(pitch - dx)
          + 48'(seed_copy[y1 * GRID_SIDE + x1]) * 48'(dx);
      blend = top * 48'(pitch - dy) + bot * 48'(dy);
      area = 48'(pitch) * 48'(pitch);
      sum = sum + (((blend + area / 2) / area) << (octs - 1 - o));
    end
    total = (48'(1) << octs) - 1;
    return SEED_W'((sum + total / 2) / total);
  endfunction

  function automatic logic [SEED_W-1:0] pick_seed();
    int r;
    if (fill_seed >= 0) return SEED_W'(fill_seed);
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return SEED_W'($urandom);
  endfunction

  task automatic queue_item(input logic func, input logic [GRID_BITS-1:0] x,
                            input logic [GRID_BITS-1:0] y, input logic [SEED_W-1:0] seed);
    items_to_send.push_back('{func: func, pos_x: x, pos_y: y, seed_value: seed});
    if (func == FUNC_LOAD) seed_written[{y, x}] = 1'b1;
    queued_count++;
  endtask

  // Every corner that any octave of the query reads is loaded first, unless it was loaded before.
  task automatic queue_query(input logic [GRID_BITS-1:0] x, input logic [GRID_BITS-1:0] y);
    int octs, o, c, pitch, cx, cy;
    octs = octaves_used(octave_cfg);
    for (o = 0; o < octs; o++) begin
      pitch = GRID_SIDE >> o;
      for (c = 0; c < 4; c++) begin
        cx = (int'(x) / pitch) * pitch;
        cy = (int'(y) / pitch) * pitch;
        if (c[0]) cx = (cx + pitch) % GRID_SIDE;
        if (c[1]) cy = (cy + pitch) % GRID_SIDE;
        if (!seed_written[cy * GRID_SIDE + cx]) begin
          queue_item(FUNC_LOAD, GRID_BITS'(cx), GRID_BITS'(cy), pick_seed());
        end
      end
    end
    queue_item(FUNC_QUERY, x, y, SEED_W'($urandom));
  endtask

  task automatic apb_access(input logic write, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (write && addr == OCT_ADDR) octave_cfg = data[OCT_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_octaves(input logic [OCT_W-1:0] value);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, OCT_ADDR, {28'($urandom), value}, rd);
    apb_access(1'b1, SPARE_ADDR, APB_DW'($urandom), rd);
    apb_access(1'b0, OCT_ADDR, '0, rd);
    if (rd !== APB_DW'(octave_cfg)) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("octave register readback: expected %0d, actual %0d", octave_cfg, rd);
      end
    end
  endtask

  task automatic drain();
    while (items_to_send.size() != 0 || in_ch.valid || noise_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (in_gap == 0 && !quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 8);
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (items_to_send.size() > 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.payload <= items_to_send.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_gap == 0 && !quiet && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 8);
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    bit        out_taken;
    in_taken  = in_ch.valid && in_ch.ready;
    out_taken = out_ch.valid && out_ch.ready;
    if (rst_ni) begin
      if (in_taken) begin
        if (in_ch.payload.func == FUNC_LOAD) begin
          seed_copy[{in_ch.payload.pos_y, in_ch.payload.pos_x}] = in_ch.payload.seed_value;
        end else begin
          noise_due.push_back('{noise_value: noise_at(in_ch.payload.pos_x, in_ch.payload.pos_y),
                                out_x: in_ch.payload.pos_x, out_y: in_ch.payload.pos_y});
        end
      end
      if (out_taken) begin
        if (noise_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: noise %h at (%0d,%0d)", out_ch.payload.noise_value,
                     out_ch.payload.out_x, out_ch.payload.out_y);
          end
        end else begin
          want = noise_due.pop_front();
          if (out_ch.payload !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected noise %h at (%0d,%0d), actual noise %h at (%0d,%0d)",
                       want.noise_value, want.out_x, want.out_y, out_ch.payload.noise_value,
                       out_ch.payload.out_x, out_ch.payload.out_y);
            end
          end
        end
      end
      if (in_taken || out_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("octave_value_noise_2d_unit_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [GRID_BITS-1:0] ax [4];
    logic [GRID_BITS-1:0] ay [4];
    logic [GRID_BITS-1:0] x, y;
    int                   a, ph;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    octave_cfg    = OCT_RESET;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    fill_seed = 16'hFFFF;
    queue_query(8'd0, 8'd0);
    queue_query(8'd3, 8'd5);
    queue_item(FUNC_LOAD, 8'd0, 8'd0, 16'h0000);
    queue_query(8'd0, 8'd0);
    queue_query(8'd255, 8'd255);
    fill_seed = 0;
    queue_query(8'd128, 8'd200);
    fill_seed = -1;
    queue_query(8'd4, 8'd4);
    queue_query(8'd255, 8'd0);
    queue_query(8'd0, 8'd255);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      set_octaves(phase_octs[ph]);
      quiet = (ph == NUM_PHASES - 1);
      for (a = 0; a < 3; a++) begin
        ax[a] = GRID_BITS'($urandom);
        ay[a] = GRID_BITS'($urandom);
      end
      ax[3] = GRID_BITS'($urandom_range(240, 255));
      ay[3] = GRID_BITS'($urandom_range(240, 255));
      queued_count = 0;
      while (queued_count < PHASE_ITEMS) begin
        a = $urandom_range(0, 3);
        if ($urandom_range(0, 4) == 0) begin
          x = GRID_BITS'($urandom);
          y = GRID_BITS'($urandom);
        end else begin
          x = ax[a] + GRID_BITS'($urandom_range(0, 15));
          y = ay[a] + GRID_BITS'($urandom_range(0, 15));
        end
        if ($urandom_range(0, 6) == 0) queue_item(FUNC_LOAD, x, y, pick_seed());
        else queue_query(x, y);
      end
      drain();
    end

    if (mismatches == 0 && noise_due.size() == 0) begin
      $display("octave_value_noise_2d_unit_tb: PASS");
    end else begin
      $display("octave_value_noise_2d_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
